// File: design/sgs_pkg.sv
// Shared widths, item codes and register indexes of the sparse Gauss-Seidel sweep block.
package sgs_pkg;

    // Field widths of items and results
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 9;
    localparam int COL_W    = 6;
    localparam int DATA_W   = 32;
    localparam int ROW_W    = 6;
    localparam int PTR_W    = 10;
    localparam int COUNT_W  = 7;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam int FRAC_W   = 16;

    // Default sizes
    localparam int DEF_MAX_UNKNOWNS = 64;
    localparam int DEF_MAX_NONZEROS = 512;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ROW_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NONZERO   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RHS       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SOLUTION  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RUN       = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_MODE    = 1'b1;

    // Sweep modes
    localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACKWARD = 2'd1;

endpackage

// File: design/sgs_if.sv
// Item and result channel interfaces of the sparse Gauss-Seidel sweep block.
interface sgs_item_if import sgs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [SLOT_W-1:0]        slot;
    logic [COL_W-1:0]         column;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, kind, slot, column, value, input ready);
    modport sink   (input valid, kind, slot, column, value, output ready);
endinterface

interface sgs_result_if import sgs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ROW_W-1:0]         row;
    logic signed [DATA_W-1:0] solution;
    logic                     singular_row;
    logic                     last;

    modport source (output valid, row, solution, singular_row, last, input ready);
    modport sink   (input valid, row, solution, singular_row, last, output ready);
endinterface

// File: design/sparse_gauss_seidel_sweep_top.sv
// Items, load and run alike, are taken only while the block is idle.
// Run per row: the row start reads, each nonzero entry in turn and then the 48-step
// restoring divider, whose result is written to the solution memory; a row with
// no usable diagonal skips the divider. Emission then sends the rows in order.
// Reset clears control, singular flags and solution valid bits and sets the configuration
// to its defaults at once; there is no clearing pass.
module sparse_gauss_seidel_sweep_top import sgs_pkg::*; #(
    parameter int MAX_UNKNOWNS = DEF_MAX_UNKNOWNS,
    parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sgs_item_if.sink              items,
    sgs_result_if.source          results,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    localparam int RW  = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
    localparam int RSW = $clog2(MAX_UNKNOWNS + 1);
    localparam int NW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int DVD_W = DATA_W + FRAC_W;
    localparam int CNT_W = $clog2(DVD_W);

    typedef enum logic [3:0] {
        S_IDLE, S_RS0, S_RS1, S_RS2, S_NZ_RD, S_NZ_CHK, S_MUL, S_ACC,
        S_DIV_START, S_DIV, S_DIV_END, S_NEXT, S_EMIT_RD, S_EMIT_WAIT
    } state_t;

    // Memories and their registered read data
    logic [PTR_W-1:0]          rs_mem  [MAX_UNKNOWNS+1];
    logic [COL_W+DATA_W-1:0]   nz_mem  [MAX_NONZEROS];
    logic [DATA_W-1:0]         rhs_mem [MAX_UNKNOWNS];
    logic [DATA_W-1:0]         sol_mem [MAX_UNKNOWNS];
    logic [PTR_W-1:0]          rs_rdata_reg;
    logic [COL_W+DATA_W-1:0]   nz_rdata_reg;
    logic [DATA_W-1:0]         rhs_rdata_reg;
    logic [DATA_W-1:0]         sol_rdata_reg;
    logic                      sol_rvalid_reg;
    logic [MAX_UNKNOWNS-1:0]   sol_valid_reg;
    logic [MAX_UNKNOWNS-1:0]   flag_reg;

    // Control and datapath registers
    state_t                    state_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic [COUNT_W-1:0]        n_reg;
    logic [RW-1:0]             row_reg;
    logic                      backward_reg;
    logic                      second_reg;
    logic [PTR_W-1:0]          k_reg;
    logic [PTR_W-1:0]          end_reg;
    logic signed [DATA_W-1:0]  w_reg;
    logic signed [DATA_W-1:0]  diag_reg;
    logic signed [DATA_W-1:0]  val_reg;
    logic                      xzero_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic [DVD_W-1:0]          dvd_reg;
    logic [DATA_W-1:0]         dvs_reg;
    logic [DATA_W-1:0]         rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      neg_reg;
    logic                      out_valid_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic [DATA_W-1:0]         out_sol_reg;
    logic                      out_flag_reg;
    logic                      out_last_reg;

    // Combinational helpers
    logic                      in_acc;
    logic [COUNT_W-1:0]        run_n;
    logic                      row_last;
    logic [RSW-1:0]            rs_raddr;
    logic [RW-1:0]             sol_raddr;
    logic [COL_W-1:0]          nz_col;
    logic signed [DATA_W-1:0]  nz_val;
    logic signed [DATA_W-1:0]  x_val;
    logic signed [2*DATA_W-1:0] prod_sh;
    logic signed [DATA_W-1:0]  qm;
    logic signed [DATA_W:0]    w_diff;
    logic signed [DATA_W-1:0]  w_sat;
    logic [PTR_W-1:0]          end_clip;
    logic [DATA_W:0]           rem_sh;
    logic                      q_bit;
    logic [DATA_W-1:0]         div_res;
    logic [DATA_W-1:0]         w_abs;
    logic [DATA_W-1:0]         diag_abs;
    logic                      sol_we;
    logic [RW-1:0]             sol_waddr;
    logic [DATA_W-1:0]         sol_wdata;
    logic                      out_free;

    assign in_acc        = items.valid && items.ready;
    assign items.ready   = (state_reg == S_IDLE);
    assign results.valid = out_valid_reg;
    assign results.row   = out_row_reg;
    assign results.solution     = out_sol_reg;
    assign results.singular_row = out_flag_reg;
    assign results.last  = out_last_reg;
    assign out_free      = !out_valid_reg || results.ready;

    // Clamp the unknown count and find the final row
    always_comb
    begin
        if (count_reg == '0)
            run_n = COUNT_W'(1);
        else if (32'(count_reg) > MAX_UNKNOWNS)
            run_n = COUNT_W'(MAX_UNKNOWNS);
        else
            run_n = count_reg;
        row_last = (32'(row_reg) == 32'(n_reg) - 1);
    end

    // Select read addresses
    always_comb
    begin
        nz_col = nz_rdata_reg[COL_W+DATA_W-1:DATA_W];
        nz_val = nz_rdata_reg[DATA_W-1:0];
        if (state_reg == S_RS0)
            rs_raddr = RSW'(row_reg);
        else
            rs_raddr = RSW'(row_reg) + RSW'(1);
        if (state_reg == S_NZ_CHK)
            sol_raddr = RW'(nz_col);
        else
            sol_raddr = row_reg;
    end

    // Scale the product and accumulate with saturation
    always_comb
    begin
        x_val   = (xzero_reg || !sol_rvalid_reg) ? '0 : sol_rdata_reg;
        prod_sh = prod_reg >>> FRAC_W;
        if (prod_sh > 64'sh7FFF_FFFF)
            qm = 32'sh7FFF_FFFF;
        else if (prod_sh < -64'sh8000_0000)
            qm = -32'sh8000_0000;
        else
            qm = prod_sh[DATA_W-1:0];
        w_diff = {w_reg[DATA_W-1], w_reg} - {qm[DATA_W-1], qm};
        if (w_diff[DATA_W] != w_diff[DATA_W-1])
            w_sat = w_diff[DATA_W] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            w_sat = w_diff[DATA_W-1:0];
        if (32'(rs_rdata_reg) > MAX_NONZEROS)
            end_clip = PTR_W'(MAX_NONZEROS);
        else
            end_clip = rs_rdata_reg;
    end

    // Divider step, operand magnitudes and final saturation
    always_comb
    begin
        w_abs    = w_reg[DATA_W-1] ? DATA_W'(-w_reg) : DATA_W'(w_reg);
        diag_abs = diag_reg[DATA_W-1] ? DATA_W'(-diag_reg) : DATA_W'(diag_reg);
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        q_bit    = (rem_sh >= {1'b0, dvs_reg});
        if (neg_reg)
        begin
            if (dvd_reg > DVD_W'(33'h0_8000_0000))
                div_res = 32'h8000_0000;
            else
                div_res = DATA_W'(-dvd_reg);
        end
        else
        begin
            if (dvd_reg > DVD_W'(32'h7FFF_FFFF))
                div_res = 32'h7FFF_FFFF;
            else
                div_res = dvd_reg[DATA_W-1:0];
        end
    end

    // Solution write port: load items and divider results
    always_comb
    begin
        sol_we    = 1'b0;
        sol_waddr = row_reg;
        sol_wdata = div_res;
        if (state_reg == S_DIV_END)
            sol_we = 1'b1;
        else if (in_acc && items.kind == KIND_SOLUTION && 32'(items.slot) < MAX_UNKNOWNS)
        begin
            sol_we    = 1'b1;
            sol_waddr = RW'(items.slot);
            sol_wdata = items.value;
        end
    end

    // Row start memory
    always_ff @(posedge clk)
    begin
        if (in_acc && items.kind == KIND_ROW_START && 32'(items.slot) <= MAX_UNKNOWNS)
            rs_mem[RSW'(items.slot)] <= items.value[PTR_W-1:0];
        rs_rdata_reg <= rs_mem[rs_raddr];
    end

    // Nonzero memory
    always_ff @(posedge clk)
    begin
        if (in_acc && items.kind == KIND_NONZERO && 32'(items.slot) < MAX_NONZEROS)
            nz_mem[NW'(items.slot)] <= {items.column, items.value};
        nz_rdata_reg <= nz_mem[NW'(k_reg)];
    end

    // Right-hand side memory
    always_ff @(posedge clk)
    begin
        if (in_acc && items.kind == KIND_RHS && 32'(items.slot) < MAX_UNKNOWNS)
            rhs_mem[RW'(items.slot)] <= items.value;
        rhs_rdata_reg <= rhs_mem[row_reg];
    end

    // Solution memory
    always_ff @(posedge clk)
    begin
        if (sol_we)
            sol_mem[sol_waddr] <= sol_wdata;
        sol_rdata_reg <= sol_mem[sol_raddr];
    end

    // Sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= COUNT_W'(1);
            mode_reg       <= MODE_FORWARD;
            n_reg          <= COUNT_W'(1);
            row_reg        <= '0;
            backward_reg   <= 1'b0;
            second_reg     <= 1'b0;
            k_reg          <= '0;
            end_reg        <= '0;
            w_reg          <= '0;
            diag_reg       <= '0;
            val_reg        <= '0;
            xzero_reg      <= 1'b0;
            prod_reg       <= '0;
            dvd_reg        <= '0;
            dvs_reg        <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            neg_reg        <= 1'b0;
            sol_valid_reg  <= '0;
            sol_rvalid_reg <= 1'b0;
            flag_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_sol_reg    <= '0;
            out_flag_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            sol_rvalid_reg <= sol_valid_reg[sol_raddr];
            if (sol_we)
                sol_valid_reg[sol_waddr] <= 1'b1;

            // Configuration writes
            if (wr_en)
            begin
                if (wr_index == REG_UNKNOWN_COUNT)
                    count_reg <= wr_data[COUNT_W-1:0];
                else if (wr_index == REG_SWEEP_MODE)
                    mode_reg <= wr_data[MODE_W-1:0];
            end

            // Drop the result once taken; the emit state handles its own cycle
            if (out_valid_reg && results.ready && state_reg != S_EMIT_WAIT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && items.kind == KIND_RUN)
                    begin
                        n_reg        <= run_n;
                        backward_reg <= (mode_reg != MODE_FORWARD);
                        second_reg   <= (mode_reg != MODE_FORWARD) &&
                                        (mode_reg != MODE_BACKWARD);
                        if (mode_reg != MODE_FORWARD)
                            row_reg <= RW'(run_n - COUNT_W'(1));
                        else
                            row_reg <= '0;
                        for (int j = 0; j < MAX_UNKNOWNS; j++)
                        begin
                            if (j < 32'(run_n))
                                flag_reg[j] <= 1'b0;
                        end
                        state_reg <= S_RS0;
                    end
                end
                S_RS0:
                    state_reg <= S_RS1;
                S_RS1:
                begin
                    k_reg     <= rs_rdata_reg;
                    w_reg     <= rhs_rdata_reg;
                    state_reg <= S_RS2;
                end
                S_RS2:
                begin
                    end_reg   <= end_clip;
                    diag_reg  <= '0;
                    state_reg <= S_NZ_RD;
                end
                S_NZ_RD:
                begin
                    if (k_reg < end_reg)
                        state_reg <= S_NZ_CHK;
                    else
                        state_reg <= S_DIV_START;
                end
                S_NZ_CHK:
                begin
                    if (32'(nz_col) == 32'(row_reg))
                    begin
                        diag_reg  <= nz_val;
                        k_reg     <= k_reg + PTR_W'(1);
                        state_reg <= S_NZ_RD;
                    end
                    else
                    begin
                        val_reg   <= nz_val;
                        xzero_reg <= (32'(nz_col) >= MAX_UNKNOWNS);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= val_reg * x_val;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    w_reg     <= w_sat;
                    k_reg     <= k_reg + PTR_W'(1);
                    state_reg <= S_NZ_RD;
                end
                S_DIV_START:
                begin
                    if (diag_reg == '0)
                    begin
                        flag_reg[row_reg] <= 1'b1;
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        dvd_reg   <= {w_abs, FRAC_W'(0)};
                        dvs_reg   <= diag_abs;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        neg_reg   <= w_reg[DATA_W-1] ^ diag_reg[DATA_W-1];
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // One quotient bit per cycle
                    if (q_bit)
                        rem_reg <= DATA_W'(rem_sh - {1'b0, dvs_reg});
                    else
                        rem_reg <= rem_sh[DATA_W-1:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (32'(cnt_reg) == DVD_W - 1)
                        state_reg <= S_DIV_END;
                end
                S_DIV_END:
                    state_reg <= S_NEXT;
                S_NEXT:
                begin
                    // Advance the row, then the pass
                    if ((backward_reg && row_reg == '0) || (!backward_reg && row_last))
                    begin
                        row_reg <= '0;
                        if (second_reg)
                        begin
                            second_reg   <= 1'b0;
                            backward_reg <= 1'b0;
                            state_reg    <= S_RS0;
                        end
                        else
                            state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        if (backward_reg)
                            row_reg <= row_reg - RW'(1);
                        else
                            row_reg <= row_reg + RW'(1);
                        state_reg <= S_RS0;
                    end
                end
                S_EMIT_RD:
                    state_reg <= S_EMIT_WAIT;
                S_EMIT_WAIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_row_reg   <= ROW_W'(row_reg);
                        out_sol_reg   <= sol_rvalid_reg ? sol_rdata_reg : '0;
                        out_flag_reg  <= flag_reg[row_reg];
                        out_last_reg  <= row_last;
                        if (row_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            row_reg   <= row_reg + RW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> 32'(cnt_reg) < DVD_W)
        else $error("divider ran past its step count");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV_END |-> dvs_reg != '0)
        else $error("division result written for a zero diagonal");

    a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NZ_CHK |-> k_reg < end_reg)
        else $error("nonzero read beyond row end");

    a_out_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> 32'(out_row_reg) < 32'(n_reg))
        else $error("emitted row beyond unknown count");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of the sparse Gauss-Seidel sweep block: loads, sweeps, checks.
module tb_top;
    import sgs_pkg::*;

    // Spare item kinds that the block drops, a spare sweep mode and test sizes
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE     = 2'd3;
    localparam int N_ROWS = DEF_MAX_UNKNOWNS;
    localparam int N_NZ   = DEF_MAX_NONZEROS;
    localparam int ITEM_GOAL = 360;
    localparam int CALM_FROM = 300;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] solution;
        logic                     singular_row;
        logic                     last;
    } sol_entry_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [COL_W-1:0]  column;
        logic [DATA_W-1:0] value;
        bit                typed;
        logic [DATA_W-1:0] want_solution;
        bit                want_singular;
    } step_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    sgs_item_if   items ();
    sgs_result_if results ();

    sparse_gauss_seidel_sweep_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .results  (results),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Shadow copy of the block's stores and registers
    logic [PTR_W-1:0]         sh_ptr [N_ROWS+1];
    logic [COL_W-1:0]         sh_col [N_NZ];
    logic signed [DATA_W-1:0] sh_val [N_NZ];
    logic signed [DATA_W-1:0] sh_rhs [N_ROWS];
    logic signed [DATA_W-1:0] sh_sol [N_ROWS];
    bit                       sh_flag [N_ROWS];
    logic [COUNT_W-1:0]       sh_count;
    logic [MODE_W-1:0]        sh_mode;

    sol_entry_t pending_rows[$];
    int  errors = 0;
    int  items_sent;
    int  cycles = 0;
    bit  calm;
    bit  steady;
    int  stall_left = 0;

    // Clock and cycle limit
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    function automatic logic signed [DATA_W-1:0] sat32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] q_mul(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        longint p;
        longint q;
        p = longint'(a) * longint'(b);
        if (p >= 0) q = p >>> FRAC_W;
        else q = -(((-p) + 65535) >>> FRAC_W);
        return sat32(q);
    endfunction

    // Relax one row in place against the current solution
    function automatic void relax_row(input int r);
        int s;
        int e;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] diag;
        logic signed [DATA_W-1:0] x;
        s = sh_ptr[r];
        e = sh_ptr[r+1];
        w = sh_rhs[r];
        diag = 0;
        if (e > N_NZ) e = N_NZ;
        for (int k = s; k < e; k++)
        begin
            if (sh_col[k] == r) diag = sh_val[k];
            else
            begin
                x = sh_sol[sh_col[k]];
                w = sat32(longint'(w) - longint'(q_mul(sh_val[k], x)));
            end
        end
        if (diag == 0) sh_flag[r] = 1'b1;
        else sh_sol[r] = sat32((longint'(w) * 65536) / longint'(diag));
    endfunction

    // Apply one accepted item to the shadow state; return the entries a run emits
    function automatic void apply_item(input logic [KIND_W-1:0] kind,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [COL_W-1:0] column,
                                       input logic [DATA_W-1:0] value,
                                       ref sol_entry_t out[$]);
        int n;
        sol_entry_t ent;
        out.delete();
        case (kind)
            KIND_ROW_START: if (slot <= N_ROWS) sh_ptr[slot] = value[PTR_W-1:0];
            KIND_NONZERO:
            begin
                sh_col[slot] = column;
                sh_val[slot] = value;
            end
            KIND_RHS:      if (slot < N_ROWS) sh_rhs[slot] = value;
            KIND_SOLUTION: if (slot < N_ROWS) sh_sol[slot] = value;
            KIND_RUN:
            begin
                n = sh_count;
                if (n < 1) n = 1;
                if (n > N_ROWS) n = N_ROWS;
                for (int i = 0; i < n; i++) sh_flag[i] = 1'b0;
                if (sh_mode != MODE_FORWARD)
                    for (int t = 0; t < n; t++) relax_row(n - 1 - t);
                if (sh_mode != MODE_BACKWARD)
                    for (int t = 0; t < n; t++) relax_row(t);
                for (int i = 0; i < n; i++)
                begin
                    ent.row = i;
                    ent.solution = sh_sol[i];
                    ent.singular_row = sh_flag[i];
                    ent.last = (i == n - 1);
                    out.push_back(ent);
                end
            end
            default: ;
        endcase
    endfunction

    // Drive one item, hold it until taken, then queue what it produces
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                             input logic [COL_W-1:0] column, input logic [DATA_W-1:0] value,
                             input bit typed = 0, input logic [DATA_W-1:0] want_sol = 0,
                             input bit want_sing = 0);
        sol_entry_t produced[$];
        if (!calm && !steady && $urandom_range(0, 4) == 0)
        begin
            items.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        items.valid  = 1'b1;
        items.kind   = kind;
        items.slot   = slot;
        items.column = column;
        items.value  = value;
        do @(posedge clk); while (!items.ready);
        apply_item(kind, slot, column, value, produced);
        if (typed && produced.size() == 1)
        begin
            produced[0].solution = want_sol;
            produced[0].singular_row = want_sing;
        end
        foreach (produced[i]) pending_rows.push_back(produced[i]);
        @(negedge clk);
    endtask

    // Wait until every row is back and the block has settled
    task automatic wait_idle();
        items.valid = 1'b0;
        while (pending_rows.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = data;
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == REG_UNKNOWN_COUNT) sh_count = data;
        else sh_mode = data[MODE_W-1:0];
    endtask

    function automatic logic [DATA_W-1:0] rand_fixed(input int whole);
        int lim;
        lim = whole * 65536;
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    // Item that the block ignores: spare kind or slot beyond its store
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(KIND_SPARE_A + $urandom_range(0, 2), $urandom, $urandom, $urandom);
            1: send_item(KIND_ROW_START, $urandom_range(N_ROWS + 1, 511), $urandom, $urandom);
            2: send_item(KIND_RHS, $urandom_range(N_ROWS, 511), $urandom, $urandom);
            default: send_item(KIND_SOLUTION, $urandom_range(N_ROWS, 511), $urandom, $urandom);
        endcase
    endtask

    // Load a random system for n rows, then sweep it a few times
    task automatic load_and_sweep(input int n);
        int p[N_ROWS+1];
        int e;
        int r;
        logic [COL_W-1:0] c;
        logic [DATA_W-1:0] v;
        bit tail;
        tail = ($urandom_range(0, 11) == 0);
        p[0] = tail ? 500 : $urandom_range(0, 30);
        for (int i = 0; i < n; i++)
            p[i+1] = p[i] + (($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3));
        if (tail) p[n] = $urandom_range(513, 1023);
        if (n > 1 && $urandom_range(0, 9) == 0)
        begin
            r = $urandom_range(1, n - 1);
            p[r] = p[r+1] + $urandom_range(0, 3);
        end
        for (int i = 0; i <= n; i++)
        begin
            send_item(KIND_ROW_START, i, $urandom, {$urandom_range(0, 4194303), p[i][PTR_W-1:0]});
            if ($urandom_range(0, 7) == 0) send_noise();
            items_sent++;
        end
        for (int i = 0; i < n; i++)
        begin
            e = (p[i+1] > N_NZ) ? N_NZ : p[i+1];
            for (int k = p[i]; k < e; k++)
            begin
                if ($urandom_range(0, 2) == 0) c = i;
                else if ($urandom_range(0, 3) == 0) c = $urandom_range(0, 63);
                else c = $urandom_range(0, n - 1);
                if (c == i)
                    case ($urandom_range(0, 9))
                        0: v = 0;
                        1: v = $urandom;
                        default: v = rand_fixed(8);
                    endcase
                else
                    v = ($urandom_range(0, 7) == 0) ? $urandom : rand_fixed(1);
                send_item(KIND_NONZERO, k, c, v);
                items_sent++;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            send_item(KIND_RHS, i, $urandom,
                      ($urandom_range(0, 5) == 0) ? $urandom : rand_fixed(16));
            items_sent++;
            if ($urandom_range(0, 3) == 0)
            begin
                send_item(KIND_SOLUTION, i, $urandom, rand_fixed(4));
                items_sent++;
            end
        end
        repeat ($urandom_range(1, 3))
        begin
            send_item(KIND_RUN, $urandom, $urandom, $urandom);
            items_sent++;
        end
    endtask

    // Result side: random stall bursts, checked against the oldest expected row
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            results.ready = 1'b0;
        end
        else if (rst_n && !calm && !steady && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            results.ready = 1'b0;
        end
        else
            results.ready = 1'b1;
    end

    always @(posedge clk)
    begin
        sol_entry_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_rows.size() == 0)
                report($sformatf("unexpected row %0d", results.row));
            else
            begin
                want = pending_rows.pop_front();
                if (results.row !== want.row)
                    report($sformatf("row %0d, want %0d", results.row, want.row));
                if (results.solution !== want.solution)
                    report($sformatf("row %0d solution %h, want %h", want.row,
                                     results.solution, want.solution));
                if (results.singular_row !== want.singular_row)
                    report($sformatf("row %0d singular %b, want %b", want.row,
                                     results.singular_row, want.singular_row));
                if (results.last !== want.last)
                    report($sformatf("row %0d last %b, want %b", want.row,
                                     results.last, want.last));
            end
        end
    end

    // Stimulus
    initial
    begin
        step_t directed[23];
        int n;
        logic [CFG_DATA_W-1:0] cnt;
        directed = '{
            '{KIND_ROW_START, 9'd0,   6'd0,  32'h00000000, 0, 0, 0},
            '{KIND_ROW_START, 9'd1,   6'd0,  32'hFFFFFC01, 0, 0, 0},
            '{KIND_NONZERO,   9'd0,   6'd0,  32'h00010000, 0, 0, 0},
            '{KIND_RHS,       9'd0,   6'd0,  32'h7FFFFFFF, 0, 0, 0},
            '{KIND_RUN,       9'd0,   6'd0,  32'h00000000, 1, 32'h7FFFFFFF, 0},
            '{KIND_NONZERO,   9'd0,   6'd0,  32'h00000000, 0, 0, 0},
            '{KIND_RUN,       9'd511, 6'd63, 32'hFFFFFFFF, 1, 32'h7FFFFFFF, 1},
            '{KIND_NONZERO,   9'd0,   6'd0,  32'h00008000, 0, 0, 0},
            '{KIND_RHS,       9'd0,   6'd0,  32'h80000000, 0, 0, 0},
            '{KIND_RUN,       9'd0,   6'd0,  32'h00000000, 1, 32'h80000000, 0},
            '{KIND_NONZERO,   9'd0,   6'd0,  32'hFFFF0000, 0, 0, 0},
            '{KIND_RUN,       9'd0,   6'd0,  32'h00000000, 1, 32'h7FFFFFFF, 0},
            '{KIND_ROW_START, 9'd511, 6'd63, 32'hFFFFFFFF, 0, 0, 0},
            '{KIND_ROW_START, 9'd65,  6'd0,  32'h00000000, 0, 0, 0},
            '{KIND_NONZERO,   9'd511, 6'd63, 32'h7FFFFFFF, 0, 0, 0},
            '{KIND_RHS,       9'd64,  6'd0,  32'h00000000, 0, 0, 0},
            '{KIND_SOLUTION,  9'd511, 6'd63, 32'hFFFFFFFF, 0, 0, 0},
            '{KIND_SPARE_A,   9'd0,   6'd0,  32'h00000000, 0, 0, 0},
            '{KIND_SPARE_B,   9'd0,   6'd0,  32'h00000000, 0, 0, 0},
            '{KIND_SPARE_C,   9'd511, 6'd63, 32'hFFFFFFFF, 0, 0, 0},
            '{KIND_SOLUTION,  9'd0,   6'd0,  32'h00030000, 0, 0, 0},
            '{KIND_NONZERO,   9'd0,   6'd0,  32'h00020000, 0, 0, 0},
            '{KIND_RUN,       9'd0,   6'd0,  32'h00000000, 0, 0, 0}
        };
        items_sent = 0;
        calm = 0;
        steady = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_UNKNOWN_COUNT;
        wr_data = '0;
        items.valid = 1'b0;
        items.kind = KIND_ROW_START;
        items.slot = '0;
        items.column = '0;
        items.value = '0;
        sh_count = 1;
        sh_mode = MODE_FORWARD;
        foreach (sh_sol[i]) sh_sol[i] = 0;
        foreach (sh_flag[i]) sh_flag[i] = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table, one row at a time
        foreach (directed[i])
            send_item(directed[i].kind, directed[i].slot, directed[i].column,
                      directed[i].value, directed[i].typed, directed[i].want_solution,
                      directed[i].want_singular);
        wait_idle();

        // Unknown count zero acts as one, spare mode acts as symmetric
        write_reg(REG_UNKNOWN_COUNT, 0);
        write_reg(REG_SWEEP_MODE, MODE_SPARE);
        send_item(KIND_RUN, 0, 0, 0);
        wait_idle();

        // Random phases of load, configure and sweep
        while (items_sent < ITEM_GOAL)
        begin
            calm = (items_sent >= CALM_FROM);
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0:       cnt = 127;
                1:       cnt = 64;
                2, 3:    cnt = $urandom_range(9, 24);
                default: cnt = $urandom_range(1, 8);
            endcase
            n = (cnt > N_ROWS) ? N_ROWS : cnt;
            write_reg(REG_UNKNOWN_COUNT, cnt);
            write_reg(REG_SWEEP_MODE, $urandom_range(MODE_FORWARD, MODE_SPARE));
            load_and_sweep(n);
            wait_idle();
        end

        // Drain and decide
        items.valid = 1'b0;
        while (pending_rows.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
